// ===== design/mba_pkg.sv =====
// Shared constants, types and helpers for the multichannel block averager.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mba_pkg;

   localparam int NUM_CH          = 8;
   localparam int NUM_MOTORS      = 4;
   localparam int EMF_W           = 15;
   localparam int CUR_W           = 17;
   localparam int MILLI_DIV       = 1000;
   localparam int CUR_SHIFT       = 2;     // current gain of four
   localparam int STEP_BITS       = 4;     // quotient bits resolved per divider stage
   localparam int WINDOW_DEF      = 25;
   localparam int SAMPLE_BITS_DEF = 24;

   typedef struct packed {
      logic take;   // a transaction is accepted this cycle
      logic last;   // it closes the window
   } lane_ctl_type;

   typedef struct packed {
      logic [NUM_MOTORS-1:0][EMF_W-1:0] emf;
      logic [NUM_MOTORS-1:0][CUR_W-1:0] cur;
   } result_type;

   // Pipeline stages of a constant divider for a dividend of the given width.
   function automatic int div_stages(input int width);
      return (width + STEP_BITS - 1) / STEP_BITS;
   endfunction

endpackage

`default_nettype wire

// ===== design/mba_cdiv.sv =====
// Pipelined unsigned divider by a constant, STEP_BITS quotient bits per stage.
// Depends on mba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mba_cdiv
   import mba_pkg::*;
#(
   parameter int IN_W    = 29,
   parameter int DIVISOR = 25
) (
   input  wire logic            clock,
   input  wire logic [IN_W-1:0] dividend,
   input  wire logic            sign_in,
   output logic      [IN_W-1:0] quotient,
   output logic                 sign_out
);

   localparam int NST = div_stages(IN_W);
   localparam int PW  = NST * STEP_BITS;
   localparam int RW  = $clog2(DIVISOR + 1);
   localparam logic [RW:0] DIV_C = (RW+1)'(DIVISOR);

   logic [PW-1:0] work_ff [NST];
   logic [PW-1:0] work_in [NST];
   logic [RW-1:0] rem_ff  [NST];
   logic [RW-1:0] rem_in  [NST];
   logic          sign_ff [NST];

   always_comb begin
      logic [PW-1:0] w;
      logic [RW-1:0] r;
      logic [RW:0]   t;
      for (int s = 0; s < NST; s++) begin
         if (s == 0) begin
            w = PW'(dividend);
            r = '0;
         end else begin
            w = work_ff[s-1];
            r = rem_ff[s-1];
         end
         // restoring long division: shift in one dividend bit, subtract if it fits
         for (int k = 0; k < STEP_BITS; k++) begin
            t = {r, w[PW-1]};
            w = {w[PW-2:0], 1'b0};
            if (t >= DIV_C) begin
               t    = t - DIV_C;
               w[0] = 1'b1;
            end
            r = t[RW-1:0];
         end
         work_in[s] = w;
         rem_in[s]  = r;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NST; s++) begin
         work_ff[s] <= work_in[s];
         rem_ff[s]  <= rem_in[s];
         sign_ff[s] <= (s == 0) ? sign_in : sign_ff[(s == 0) ? 0 : s-1];
      end
   end

   assign quotient = work_ff[NST-1][IN_W-1:0];
   assign sign_out = sign_ff[NST-1];

endmodule

`default_nettype wire

// ===== design/mba_lane.sv =====
// One channel lane: accumulator, magnitude stage, division by the window,
// scaling and division by 1000, signed result. Depends on mba_pkg, mba_cdiv.
`timescale 1ns / 1ps
`default_nettype none

module mba_lane
   import mba_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SUM_W       = SAMPLE_BITS_DEF + 5,
   parameter int SHIFT       = 0,
   parameter int OUT_W       = EMF_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lane_ctl_type           ctl,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   output logic      [OUT_W-1:0]       result
);

   localparam int AW = SAMPLE_BITS + CUR_SHIFT;
   localparam int EW = (AW > OUT_W) ? AW : OUT_W;

   logic signed [SUM_W-1:0] sample_ext;
   logic signed [SUM_W-1:0] acc;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] total_ff, total_in;
   logic        [SUM_W-1:0] mag_ff, mag_in;
   logic                    neg_ff;
   logic        [SUM_W-1:0] q_avg;
   logic                    sign_avg;
   logic        [AW-1:0]    scaled;
   logic        [AW-1:0]    q_milli;
   logic                    sign_milli;
   logic        [EW-1:0]    q_ext;
   logic        [EW-1:0]    res_in;
   logic        [OUT_W-1:0] res_ff;

   assign sample_ext = SUM_W'($signed(sample));
   assign acc        = sum_ff + sample_ext;

   always_comb begin
      sum_in   = sum_ff;
      total_in = total_ff;
      if (ctl.take) begin
         if (ctl.last) begin
            total_in = acc;
            sum_in   = '0;
         end else begin
            sum_in = acc;
         end
      end
   end

   assign mag_in = total_ff[SUM_W-1] ? SUM_W'(-total_ff) : SUM_W'(total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
      mag_ff   <= mag_in;
      neg_ff   <= total_ff[SUM_W-1];
   end

   mba_cdiv #(.IN_W(SUM_W), .DIVISOR(WINDOW)) u_div_win (
      .clock    (clock),
      .dividend (mag_ff),
      .sign_in  (neg_ff),
      .quotient (q_avg),
      .sign_out (sign_avg)
   );

   // average magnitude never exceeds half the sample range
   assign scaled = AW'(q_avg[SAMPLE_BITS-1:0]) << SHIFT;

   mba_cdiv #(.IN_W(AW), .DIVISOR(MILLI_DIV)) u_div_milli (
      .clock    (clock),
      .dividend (scaled),
      .sign_in  (sign_avg),
      .quotient (q_milli),
      .sign_out (sign_milli)
   );

   assign q_ext  = EW'(q_milli);
   assign res_in = sign_milli ? EW'(-q_ext) : q_ext;

   always_ff @(posedge clock) begin
      res_ff <= res_in[OUT_W-1:0];
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ===== design/mba_merge.sv =====
// Merge stage: gathers the eight lane results into one result and queues it.
// Depends on mba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mba_merge
   import mba_pkg::*;
#(
   parameter int DEPTH = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [EMF_W-1:0] emf [NUM_MOTORS],
   input  wire logic [CUR_W-1:0] cur [NUM_MOTORS],
   input  wire logic             pop,
   output result_type            head,
   output logic                  not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type       entry_ff [DEPTH];
   result_type       packed_res;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         packed_res.emf[m] = emf[m];
         packed_res.cur[m] = cur[m];
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= packed_res;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);

endmodule

`default_nettype wire

// ===== design/multichannel_block_averager.sv =====
// Top level of the multichannel block averager: eight accumulate-and-divide lanes,
// window control, result queue with credit-based input throttling.
// Depends on mba_pkg, mba_lane, mba_merge.
`timescale 1ns / 1ps
`default_nettype none

// Each request transaction carries one simultaneous set of eight signed samples.
// Every set is added into its own channel accumulator; after WINDOW sets the block
// forms each channel average (signed, truncated toward zero), clears the
// accumulators and produces one response: per motor the even channel average
// divided by 1000 (back-EMF, mV) and four times the odd channel average divided
// by 1000 (current, mA), both truncated toward zero. One request transaction is
// taken every clock cycle, except that a window-closing transaction waits while
// req_stall is high. A response passes through the total and magnitude registers,
// two constant dividers that resolve four quotient bits per stage and an output
// register before it enters the queue. Finished responses wait in a queue two
// entries deeper than the lane pipeline; req_stall rises only on a
// window-closing transaction when every queue slot is already spoken for, so a
// response held by rsp_stall holds back only that closing transaction, never the
// samples before it.
module multichannel_block_averager
   import mba_pkg::*;
#(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_0,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_1,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_2,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_3,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_4,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_5,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_6,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_7,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [EMF_W-1:0]            rsp_emf_mv_0,
   output logic signed [EMF_W-1:0]            rsp_emf_mv_1,
   output logic signed [EMF_W-1:0]            rsp_emf_mv_2,
   output logic signed [EMF_W-1:0]            rsp_emf_mv_3,
   output logic signed [CUR_W-1:0]            rsp_current_ma_0,
   output logic signed [CUR_W-1:0]            rsp_current_ma_1,
   output logic signed [CUR_W-1:0]            rsp_current_ma_2,
   output logic signed [CUR_W-1:0]            rsp_current_ma_3
);

   // accumulator wide enough for WINDOW full-scale samples of either sign
   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
   localparam int LAT    = 3 + div_stages(SUM_W) + div_stages(SAMPLE_BITS + CUR_SHIFT);
   localparam int QDEPTH = LAT + 2;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int PEND_W = $clog2(QDEPTH + 1);

   logic [SAMPLE_BITS-1:0] samples [NUM_CH];
   logic [EMF_W-1:0]       emf_q   [NUM_MOTORS];
   logic [CUR_W-1:0]       cur_q   [NUM_MOTORS];

   lane_ctl_type      lane_ctl;
   logic              req_take;
   logic              rsp_take;
   logic              last_pos;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [LAT-1:0]    flight_ff, flight_in;
   result_type        head;

   assign samples[0] = req_sample_0;
   assign samples[1] = req_sample_1;
   assign samples[2] = req_sample_2;
   assign samples[3] = req_sample_3;
   assign samples[4] = req_sample_4;
   assign samples[5] = req_sample_5;
   assign samples[6] = req_sample_6;
   assign samples[7] = req_sample_7;

   // Window position and response credits. Hold the closing transaction only
   // when the queue has no free slot for the response it would produce.
   assign last_pos  = (count_ff == CNT_W'(WINDOW - 1));
   assign req_stall = last_pos && (pend_ff == PEND_W'(QDEPTH));
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign lane_ctl.take = req_take;
   assign lane_ctl.last = last_pos;

   always_comb begin
      count_in = count_ff;
      if (req_take) begin
         count_in = last_pos ? '0 : count_ff + 1'b1;
      end
      pend_in = pend_ff;
      if ((req_take && last_pos) && !rsp_take) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_take && !(req_take && last_pos)) begin
         pend_in = pend_ff - 1'b1;
      end
      // advance the marker of each window result through the lane pipeline
      flight_in = {flight_ff[LAT-2:0], req_take && last_pos};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         pend_ff   <= '0;
         flight_ff <= '0;
      end else begin
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         flight_ff <= flight_in;
      end
   end

   // Eight lanes side by side; even channels carry back-EMF, odd channels current.
   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      if (ch % 2 == 0) begin : g_emf
         mba_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WINDOW      (WINDOW),
            .SUM_W       (SUM_W),
            .SHIFT       (0),
            .OUT_W       (EMF_W)
         ) u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctl    (lane_ctl),
            .sample (samples[ch]),
            .result (emf_q[ch/2])
         );
      end else begin : g_cur
         mba_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WINDOW      (WINDOW),
            .SUM_W       (SUM_W),
            .SHIFT       (CUR_SHIFT),
            .OUT_W       (CUR_W)
         ) u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctl    (lane_ctl),
            .sample (samples[ch]),
            .result (cur_q[ch/2])
         );
      end
   end

   mba_merge #(.DEPTH(QDEPTH)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (flight_ff[LAT-1]),
      .emf       (emf_q),
      .cur       (cur_q),
      .pop       (rsp_take),
      .head      (head),
      .not_empty (rsp_valid)
   );

   assign rsp_emf_mv_0     = $signed(head.emf[0]);
   assign rsp_emf_mv_1     = $signed(head.emf[1]);
   assign rsp_emf_mv_2     = $signed(head.emf[2]);
   assign rsp_emf_mv_3     = $signed(head.emf[3]);
   assign rsp_current_ma_0 = $signed(head.cur[0]);
   assign rsp_current_ma_1 = $signed(head.cur[1]);
   assign rsp_current_ma_2 = $signed(head.cur[2]);
   assign rsp_current_ma_3 = $signed(head.cur[3]);

endmodule

`default_nettype wire

// ===== design/mba_checker.sv =====
// Port-level checker for the multichannel block averager and its bind.
// Depends on mba_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module mba_checker
   import mba_pkg::*;
#(
   parameter int WINDOW      = WINDOW_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_0,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_1,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_2,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_3,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_4,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_5,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_6,
   input wire logic signed [SAMPLE_BITS-1:0] req_sample_7,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic signed [EMF_W-1:0]       rsp_emf_mv_0,
   input wire logic signed [EMF_W-1:0]       rsp_emf_mv_1,
   input wire logic signed [EMF_W-1:0]       rsp_emf_mv_2,
   input wire logic signed [EMF_W-1:0]       rsp_emf_mv_3,
   input wire logic signed [CUR_W-1:0]       rsp_current_ma_0,
   input wire logic signed [CUR_W-1:0]       rsp_current_ma_1,
   input wire logic signed [CUR_W-1:0]       rsp_current_ma_2,
   input wire logic signed [CUR_W-1:0]       rsp_current_ma_3
);

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int OWE_W = 6;

   logic [CNT_W-1:0] seen_ff;
   logic [OWE_W-1:0] owed_ff;
   logic             closing;
   logic             in_take;
   logic             out_take;

   assign closing  = (seen_ff == CNT_W'(WINDOW - 1));
   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;

   // track window position and responses owed, from the ports alone
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         owed_ff <= '0;
      end else begin
         if (in_take) begin
            seen_ff <= closing ? '0 : seen_ff + 1'b1;
         end
         owed_ff <= owed_ff + OWE_W'(in_take && closing) - OWE_W'(out_take);
      end
   end

   // no response without a completed window behind it
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (owed_ff != '0))
      else $error("response without a completed window");

   // input is held back only on the transaction that closes a window
   a_stall_at_close: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> closing)
      else $error("request stalled in the middle of a window");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response withdrawn");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_emf_mv_0) && $stable(rsp_emf_mv_1)
         && $stable(rsp_emf_mv_2) && $stable(rsp_emf_mv_3)
         && $stable(rsp_current_ma_0) && $stable(rsp_current_ma_1)
         && $stable(rsp_current_ma_2) && $stable(rsp_current_ma_3))
      else $error("stalled response payload changed");

endmodule

bind multichannel_block_averager mba_checker #(
   .WINDOW      (WINDOW),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_mba_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for multichannel_block_averager at its default window and width.
// Depends on mba_pkg and the multichannel_block_averager RTL; needs no other files.
`timescale 1ns / 1ps

module tb
   import mba_pkg::*;
();

   localparam int WINDOW        = WINDOW_DEF;
   localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
   localparam int CURRENT_GAIN  = 4;
   localparam int RANDOM_WINDOWS = 71;      // plus one directed window: 1800 sets
   localparam int DRAIN_CYCLES  = 40;       // more than the pipeline latency at the defaults
   localparam int CYCLE_LIMIT   = 100000;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG1 = {SAMPLE_BITS{1'b1}};

   typedef logic [NUM_CH-1:0][SAMPLE_BITS-1:0] sample_set_type;

   // How the samples of one random window are drawn.
   typedef enum int {
      STYLE_RANDOM,     // every bit random
      STYLE_RAIL,       // each channel pinned to a rail, zero or minus one, with flips
      STYLE_NEAR_ZERO,  // small values: truncation toward zero of negative averages
      STYLE_STEADY      // a steady level per channel plus noise
   } window_style_type;

   // Running window sums per channel and the readouts they must produce.
   class motor_average_model;
      longint     chan_sum [NUM_CH];
      int         sets_taken;
      result_type readouts_due [$];
      int         mismatches;

      function new();
         foreach (chan_sum[ch]) chan_sum[ch] = 0;
         sets_taken = 0;
         mismatches = 0;
      endfunction

      // Accumulate one accepted sample set; close the window when it is full.
      function void take_set(input sample_set_type s);
         longint     avg [NUM_CH];
         result_type due;
         int         m;
         foreach (chan_sum[ch]) chan_sum[ch] += longint'($signed(s[ch]));
         sets_taken++;
         if (sets_taken < WINDOW) return;
         foreach (avg[ch]) begin
            avg[ch] = chan_sum[ch] / WINDOW;
            chan_sum[ch] = 0;
         end
         sets_taken = 0;
         for (m = 0; m < NUM_MOTORS; m++) begin
            due.emf[m] = EMF_W'(avg[2*m] / MILLI_DIV);
            due.cur[m] = CUR_W'((CURRENT_GAIN * avg[2*m+1]) / MILLI_DIV);
         end
         readouts_due.push_back(due);
      endfunction

      function void flag(input string what, input longint due_v, input longint got_v);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, due_v, got_v);
      endfunction

      // Compare one accepted response against the oldest readout due.
      function void check_readout(input result_type got);
         result_type due;
         int         m;
         if (readouts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: emf_mv_0 %0d, current_ma_0 %0d",
                        $signed(got.emf[0]), $signed(got.cur[0]));
            return;
         end
         due = readouts_due.pop_front();
         for (m = 0; m < NUM_MOTORS; m++) begin
            if (got.emf[m] !== due.emf[m])
               flag($sformatf("emf_mv_%0d", m), $signed(due.emf[m]), $signed(got.emf[m]));
            if (got.cur[m] !== due.cur[m])
               flag($sformatf("current_ma_%0d", m), $signed(due.cur[m]), $signed(got.cur[m]));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample_0 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_1 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_2 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_3 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_4 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_5 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_6 = '0;
   logic [SAMPLE_BITS-1:0] req_sample_7 = '0;

   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [EMF_W-1:0] rsp_emf_mv_0, rsp_emf_mv_1, rsp_emf_mv_2, rsp_emf_mv_3;
   logic [CUR_W-1:0] rsp_current_ma_0, rsp_current_ma_1, rsp_current_ma_2, rsp_current_ma_3;

   // Idle and stall odds, in percent, for the phase under way.
   int req_idle_pct  = 12;
   int rsp_stall_pct = 85;
   int cycles        = 0;

   motor_average_model model;

   multichannel_block_averager #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_0     (req_sample_0),
      .req_sample_1     (req_sample_1),
      .req_sample_2     (req_sample_2),
      .req_sample_3     (req_sample_3),
      .req_sample_4     (req_sample_4),
      .req_sample_5     (req_sample_5),
      .req_sample_6     (req_sample_6),
      .req_sample_7     (req_sample_7),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_emf_mv_0     (rsp_emf_mv_0),
      .rsp_emf_mv_1     (rsp_emf_mv_1),
      .rsp_emf_mv_2     (rsp_emf_mv_2),
      .rsp_emf_mv_3     (rsp_emf_mv_3),
      .rsp_current_ma_0 (rsp_current_ma_0),
      .rsp_current_ma_1 (rsp_current_ma_1),
      .rsp_current_ma_2 (rsp_current_ma_2),
      .rsp_current_ma_3 (rsp_current_ma_3)
   );

   always #2 clock = ~clock;

   // Hard stop: no correct run comes anywhere near this many cycles.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: check the transaction taken at this edge (values read here are
   // the ones from before the edge), then draw the stall for the next cycle.
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.emf[0] = rsp_emf_mv_0;
         got.emf[1] = rsp_emf_mv_1;
         got.emf[2] = rsp_emf_mv_2;
         got.emf[3] = rsp_emf_mv_3;
         got.cur[0] = rsp_current_ma_0;
         got.cur[1] = rsp_current_ma_1;
         got.cur[2] = rsp_current_ma_2;
         got.cur[3] = rsp_current_ma_3;
         model.check_readout(got);
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Offer one sample set, maybe after some idle cycles, and hold it until taken.
   // Valid stays up across back-to-back transactions; it drops only to idle.
   task automatic send_set(input sample_set_type s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_sample_0 <= s[0];
      req_sample_1 <= s[1];
      req_sample_2 <= s[2];
      req_sample_3 <= s[3];
      req_sample_4 <= s[4];
      req_sample_5 <= s[5];
      req_sample_6 <= s[6];
      req_sample_7 <= s[7];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model.take_set(s);
   endtask

   initial begin
      sample_set_type         s;
      logic [SAMPLE_BITS-1:0] pick [NUM_CH];
      int                     level [NUM_CH];
      window_style_type       style;
      int                     w, k, ch;

      model = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed window. Channel by channel:
      //   motor 0 at the positive and negative rails (largest readouts),
      //   motor 1 the other way round,
      //   emf 2 sums to minus one and current 2 averages to -249: both must
      //   truncate to zero, not round down to minus one,
      //   emf 3 alternates rails, current 3 sits at a plain negative level.
      for (k = 0; k < WINDOW; k++) begin
         s[0] = SAMPLE_MAX;
         s[1] = SAMPLE_MIN;
         s[2] = SAMPLE_MIN;
         s[3] = SAMPLE_MAX;
         s[4] = (k == 0) ? SAMPLE_NEG1 : '0;
         s[5] = SAMPLE_BITS'(-249);
         s[6] = (k % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
         s[7] = SAMPLE_BITS'(-1000);
         send_set(s);
      end

      // Random windows in three phases: slow consumer, slow producer, full rate.
      for (w = 0; w < RANDOM_WINDOWS; w++) begin
         if (w == RANDOM_WINDOWS / 3) begin
            req_idle_pct  = 85;
            rsp_stall_pct = 12;
         end else if (w == 2 * RANDOM_WINDOWS / 3) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         style = window_style_type'($urandom_range(3));
         for (ch = 0; ch < NUM_CH; ch++) begin
            case ($urandom_range(3))
               0: pick[ch] = SAMPLE_MAX;
               1: pick[ch] = SAMPLE_MIN;
               2: pick[ch] = '0;
               default: pick[ch] = SAMPLE_NEG1;
            endcase
            level[ch] = int'($urandom_range(16000000)) - 8000000;
         end
         for (k = 0; k < WINDOW; k++) begin
            for (ch = 0; ch < NUM_CH; ch++) begin
               case (style)
                  STYLE_RANDOM:
                     s[ch] = SAMPLE_BITS'($urandom);
                  STYLE_RAIL:
                     s[ch] = ($urandom_range(7) == 0) ? ~pick[ch] : pick[ch];
                  STYLE_NEAR_ZERO:
                     s[ch] = SAMPLE_BITS'(int'($urandom_range(4000)) - 2000);
                  default:
                     s[ch] = SAMPLE_BITS'(level[ch] + int'($urandom_range(600000)) - 300000);
               endcase
            end
            send_set(s);
         end
      end

      // Leave a partial window behind: it must produce nothing.
      for (k = 0; k < WINDOW / 3; k++) begin
         for (ch = 0; ch < NUM_CH; ch++) s[ch] = SAMPLE_BITS'($urandom);
         send_set(s);
      end
      req_valid <= 1'b0;

      // Drain, then give any stray response time to show up.
      while (model.readouts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (model.readouts_due.size() != 0)
         $display("%0d responses never arrived", model.readouts_due.size());
      if (model.mismatches == 0 && model.readouts_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/mba_pkg.sv
design/mba_cdiv.sv
design/mba_lane.sv
design/mba_merge.sv
design/multichannel_block_averager.sv
design/mba_checker.sv
verif/tb.sv
